@@ hdl/b2da_pkg.sv @@
// Shared types and constants for the binary to decimal ASCII unit.
package b2da_pkg;

   localparam int DEFAULT_MAX_DIGITS = 10;
   localparam int DEFAULT_VALUE_BITS = 31;
   localparam int DIGIT_W            = 4;
   localparam int CHAR_W             = 6;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CLEAR,
      CELL_DABBLE,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

endpackage

@@ hdl/b2da_cell.sv @@
// One BCD digit cell: shift-add-3 step during conversion, digit shift during output.
module b2da_cell (
   input  logic                           clock,
   input  b2da_pkg::cell_ctl_type         ctl,
   input  logic                           lower_carry,
   input  logic [b2da_pkg::DIGIT_W-1:0]   lower_digit,
   output logic                           carry,
   output logic [b2da_pkg::DIGIT_W-1:0]   digit
);

   logic [b2da_pkg::DIGIT_W-1:0] digit_ff;
   logic [b2da_pkg::DIGIT_W-1:0] digit_in;
   logic [b2da_pkg::DIGIT_W-1:0] adjusted;

   assign adjusted = (digit_ff >= b2da_pkg::DIGIT_W'(5)) ?
                     digit_ff + b2da_pkg::DIGIT_W'(3) : digit_ff;

   always_comb begin
      unique case (ctl.op)
         b2da_pkg::CELL_HOLD:   digit_in = digit_ff;
         b2da_pkg::CELL_CLEAR:  digit_in = '0;
         b2da_pkg::CELL_DABBLE: digit_in = {adjusted[b2da_pkg::DIGIT_W-2:0], lower_carry};
         b2da_pkg::CELL_SHIFT:  digit_in = lower_digit;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign carry = adjusted[b2da_pkg::DIGIT_W-1];
   assign digit = digit_ff;

endmodule

@@ hdl/binary_to_decimal_ascii_unit.sv @@
// Top level: binary to decimal ASCII digit stream converter.
// An item is taken when start is high and busy is low. The value is converted
// by a row of BCD cells, one input bit per cycle, then the digits leave the
// top cell one per cycle, most significant first: leading zeros are shifted
// past without a result, then each digit is shown for one cycle with
// rsp_strobe, the final one with rsp_last_digit set. Busy stays high from
// when an item is taken until its last digit is put on the output, whatever
// the value, so no new item is taken before the last one is through.
// Results cannot be held off; the receiver must take each one in the cycle it
// is strobed. A new item may start while the last digit is shown.
module binary_to_decimal_ascii_unit #(
   parameter int MAX_DIGITS = b2da_pkg::DEFAULT_MAX_DIGITS,
   parameter int VALUE_BITS = b2da_pkg::DEFAULT_VALUE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [VALUE_BITS-1:0]         req_value,
   output logic                          rsp_strobe,
   output logic [b2da_pkg::CHAR_W-1:0]   rsp_digit_char,
   output logic                          rsp_last_digit
);

   localparam int RW = $clog2(MAX_DIGITS + 1);
   localparam int BW = $clog2(VALUE_BITS);

   b2da_pkg::state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0]           shift_ff, shift_in;
   logic [BW-1:0]                   bitcnt_ff, bitcnt_in;
   logic [RW-1:0]                   remain_ff, remain_in;
   logic                            ovf_ff, ovf_in;
   logic                            strobe_ff, strobe_in;
   logic [b2da_pkg::CHAR_W-1:0]     char_ff, char_in;
   logic                            last_ff, last_in;
   b2da_pkg::cell_ctl_type          ctl;

   logic [MAX_DIGITS:0]                       carry_chain;
   logic [MAX_DIGITS:0][b2da_pkg::DIGIT_W-1:0] digit_chain;
   logic [b2da_pkg::DIGIT_W-1:0]              top_digit;
   logic                                      top_carry;

   assign carry_chain[0] = shift_ff[VALUE_BITS-1];
   assign digit_chain[0] = '0;

   genvar g;
   generate
      for (g = 0; g < MAX_DIGITS; g++) begin : g_cell
         b2da_cell u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .lower_carry (carry_chain[g]),
            .lower_digit (digit_chain[g]),
            .carry       (carry_chain[g+1]),
            .digit       (digit_chain[g+1])
         );
      end
   endgenerate

   assign top_digit = digit_chain[MAX_DIGITS];
   assign top_carry = carry_chain[MAX_DIGITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= b2da_pkg::ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      shift_ff  <= shift_in;
      bitcnt_ff <= bitcnt_in;
      remain_ff <= remain_in;
      ovf_ff    <= ovf_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   always_comb begin
      state_in  = state_ff;
      shift_in  = shift_ff;
      bitcnt_in = bitcnt_ff;
      remain_in = remain_ff;
      ovf_in    = ovf_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = last_ff;
      ctl.op    = b2da_pkg::CELL_HOLD;
      unique case (state_ff)
         b2da_pkg::ST_IDLE: begin
            if (start) begin
               shift_in  = req_value;
               bitcnt_in = BW'(VALUE_BITS - 1);
               ovf_in    = 1'b0;
               ctl.op    = b2da_pkg::CELL_CLEAR;
               state_in  = b2da_pkg::ST_CONVERT;
            end
         end
         b2da_pkg::ST_CONVERT: begin
            ctl.op   = b2da_pkg::CELL_DABBLE;
            shift_in = {shift_ff[VALUE_BITS-2:0], 1'b0};
            ovf_in   = ovf_ff | top_carry;
            if (bitcnt_ff == '0) begin
               remain_in = RW'(MAX_DIGITS);
               state_in  = b2da_pkg::ST_SKIP;
            end else begin
               bitcnt_in = bitcnt_ff - BW'(1);
            end
         end
         b2da_pkg::ST_SKIP: begin
            if (!ovf_ff && top_digit == '0 && remain_ff > RW'(1)) begin
               ctl.op    = b2da_pkg::CELL_SHIFT;
               remain_in = remain_ff - RW'(1);
            end else begin
               state_in = b2da_pkg::ST_EMIT;
            end
         end
         b2da_pkg::ST_EMIT: begin
            ctl.op    = b2da_pkg::CELL_SHIFT;
            strobe_in = 1'b1;
            char_in   = b2da_pkg::ASCII_ZERO +
                        {{(b2da_pkg::CHAR_W - b2da_pkg::DIGIT_W){1'b0}}, top_digit};
            last_in   = (remain_ff == RW'(1));
            remain_in = remain_ff - RW'(1);
            if (remain_ff == RW'(1)) begin
               state_in = b2da_pkg::ST_IDLE;
            end
         end
      endcase
   end

   assign busy           = (state_ff != b2da_pkg::ST_IDLE);
   assign rsp_strobe     = strobe_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule
